/* src/sosf_pkg.sv */
// sosf_pkg: shared constants, types and arithmetic helpers for the fading channel
// holds the start phase and quarter sine tables, built at elaboration
// no dependencies
package sosf_pkg;

    localparam int NUM_TONES   = 16;
    localparam int TRIG_BITS   = 10;
    localparam int PHASE_DEPTH = 16;
    localparam logic [31:0] PHASE_SEED = 32'd42;

    localparam int SIN_A1 = 51472;
    localparam int SIN_A3 = 21167;
    localparam int SIN_A5 = 2463;

    localparam int QW      = TRIG_BITS - 2;
    localparam int Q_SIZE  = 1 << QW;
    localparam int PH_W    = $clog2(PHASE_DEPTH);
    localparam int TONE_W  = (NUM_TONES > 1) ? $clog2(NUM_TONES) : 1;
    localparam int ACC_W   = 16 + $clog2(NUM_TONES);
    localparam int G_W     = ACC_W + 2;
    localparam int P_W     = ACC_W + G_W;
    localparam int Y_W     = P_W + 1;

    localparam int ADDR_W  = 4;

    localparam logic [31:0] QUARTER_TURN = 32'h4000_0000;

    typedef enum logic [1:0] {
        REG_ENABLE       = 2'd0,
        REG_PHASE_STEP   = 2'd1,
        REG_SCATTER_GAIN = 2'd2,
        REG_LOS_GAIN     = 2'd3
    } reg_idx_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_TONES,
        ST_DRAIN,
        ST_MIX,
        ST_FINISH
    } state_t;

    typedef enum logic [2:0] {
        MIX_SR,
        MIX_SI,
        MIX_XR_GR,
        MIX_XI_GI,
        MIX_XR_GI,
        MIX_XI_GR,
        MIX_LAST
    } mix_step_t;

    typedef struct packed {
        logic        enable;
        logic [31:0] phase_step;
        logic [15:0] scatter_gain;
        logic [15:0] los_gain;
    } cfg_t;

    typedef logic [31:0] phase_table_t [PHASE_DEPTH];
    typedef logic [14:0] sin_table_t [Q_SIZE];

    function automatic logic [31:0] xorshift(input logic [31:0] x);
        logic [31:0] y;
        y = x ^ (x << 13);
        y = y ^ (y >> 17);
        y = y ^ (y << 5);
        return y;
    endfunction

    function automatic phase_table_t gen_phase(input logic imag);
        phase_table_t t;
        logic [31:0]  x;
        logic [31:0]  a;
        x = PHASE_SEED;
        for (int k = 0; k < PHASE_DEPTH; k++)
        begin
            x = xorshift(x);
            a = x;
            x = xorshift(x);
            t[k] = imag ? x : a;
        end
        return t;
    endfunction

    // quarter sine polynomial on unsigned q15 u in [0, 1]
    function automatic logic [14:0] qsin(input logic [16:0] u);
        logic [63:0] uu;
        logic [63:0] u2;
        logic [63:0] inner;
        logic [63:0] r;
        uu    = 64'(u);
        u2    = (uu * uu) >> 15;
        inner = 64'(SIN_A3) - ((u2 * 64'(SIN_A5)) >> 15);
        inner = 64'(SIN_A1) - ((u2 * inner) >> 15);
        r     = (uu * inner) >> 15;
        if (r > 64'd32767)
        begin
            r = 64'd32767;
        end
        return r[14:0];
    endfunction

    function automatic sin_table_t gen_sin_tab();
        sin_table_t t;
        for (int m = 0; m < Q_SIZE; m++)
        begin
            t[m] = qsin(17'(m) << (17 - TRIG_BITS));
        end
        return t;
    endfunction

    localparam phase_table_t START_RE = gen_phase(1'b0);
    localparam phase_table_t START_IM = gen_phase(1'b1);
    localparam sin_table_t   SIN_TAB  = gen_sin_tab();
    localparam logic [14:0]  QMAX     = qsin(17'h0_8000);

    function automatic logic signed [15:0] sin_lookup(input logic [TRIG_BITS-1:0] ang);
        logic [1:0]          quad;
        logic [QW-1:0]       m;
        logic [QW-1:0]       m_neg;
        logic [14:0]         mag;
        logic signed [15:0]  val;
        quad  = ang[TRIG_BITS-1 -: 2];
        m     = ang[QW-1:0];
        m_neg = ~m + 1'b1;
        if (quad[0])
        begin
            mag = (m == '0) ? QMAX : SIN_TAB[m_neg];
        end
        else
        begin
            mag = SIN_TAB[m];
        end
        val = $signed({1'b0, mag});
        return quad[1] ? -val : val;
    endfunction

    function automatic logic signed [15:0] round_sat(input logic signed [Y_W-1:0] x);
        logic signed [Y_W-1:0] t;
        t = (x + Y_W'(16384)) >>> 15;
        if (t > Y_W'(32767))
        begin
            t = Y_W'(32767);
        end
        else if (t < -Y_W'(32768))
        begin
            t = -Y_W'(32768);
        end
        return t[15:0];
    endfunction

endpackage

/* src/sosf_ifs.sv */
// sosf_ifs: valid/ready item channels for samples in and faded samples out
// no dependencies
interface sosf_in_if;
    logic               valid;
    logic               ready;
    logic signed [15:0] sample_re;
    logic signed [15:0] sample_im;
    logic               last_in;

    modport source(output valid, sample_re, sample_im, last_in, input ready);
    modport sink(input valid, sample_re, sample_im, last_in, output ready);
endinterface

interface sosf_out_if;
    logic               valid;
    logic               ready;
    logic signed [15:0] faded_re;
    logic signed [15:0] faded_im;
    logic               last_out;

    modport source(output valid, faded_re, faded_im, last_out, input ready);
    modport sink(input valid, faded_re, faded_im, last_out, output ready);
endinterface

/* src/sum_of_sinusoids_fading_channel.sv */
// sum_of_sinusoids_fading_channel: top level of the sum-of-sinusoids fading channel
// depends on sosf_pkg, sosf_ifs and sosf_regs
// an accepted item passes through the tones, one tone a cycle through the shared sine table,
// then a drain, seven steps of the shared multiplier and a load into the output register;
// when disabled it goes straight to the load
// a new item is taken only after the last one has been loaded into the output register
// reset: registers to their defaults, theta to zero, no result pending
module sum_of_sinusoids_fading_channel (
    input  logic                        clk,
    input  logic                        rst_n,
    sosf_in_if.sink                     din,
    sosf_out_if.source                  dout,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [sosf_pkg::ADDR_W-1:0] paddr,
    input  logic [31:0]                 pwdata,
    output logic [31:0]                 prdata,
    output logic                        pready
);
    import sosf_pkg::*;

    cfg_t       cfg;
    state_t     state_reg;
    state_t     state_next;
    mix_step_t  step_reg;

    logic [TONE_W-1:0]        k_reg;
    logic [31:0]              k_ext;
    logic [PH_W-1:0]          ph_idx;
    logic [31:0]              base_reg;
    logic [31:0]              theta_reg;
    logic [31:0]              full_re;
    logic [31:0]              full_im;
    logic [TRIG_BITS-1:0]     ang_re_reg;
    logic [TRIG_BITS-1:0]     ang_im_reg;
    logic                     tone_vld_reg;
    logic signed [ACC_W-1:0]  sr_reg;
    logic signed [ACC_W-1:0]  si_reg;
    logic signed [P_W-1:0]    prod_reg;
    logic signed [P_W-1:0]    prod_rnd;
    logic signed [G_W-1:0]    gr_reg;
    logic signed [G_W-1:0]    gi_reg;
    logic signed [G_W-1:0]    sg_ext;
    logic signed [G_W-1:0]    los_ext;
    logic signed [Y_W-1:0]    yr_reg;
    logic signed [Y_W-1:0]    yi_reg;
    logic signed [ACC_W-1:0]  mul_a;
    logic signed [G_W-1:0]    mul_b;
    logic signed [15:0]       xr_reg;
    logic signed [15:0]       xi_reg;
    logic                     last_reg;
    logic                     bypass_reg;
    logic                     out_valid_reg;
    logic signed [15:0]       out_re_reg;
    logic signed [15:0]       out_im_reg;
    logic                     out_last_reg;

    logic in_ready;
    logic in_acc;
    logic out_load;
    logic last_tone;

    sosf_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    assign in_acc    = din.valid && in_ready;
    assign din.ready = in_ready;
    assign last_tone = (k_reg == TONE_W'(NUM_TONES - 1));

    assign dout.valid    = out_valid_reg;
    assign dout.faded_re = out_re_reg;
    assign dout.faded_im = out_im_reg;
    assign dout.last_out = out_last_reg;

    // tone angles, only the top trig bits are kept
    assign k_ext   = 32'(k_reg);
    assign ph_idx  = k_ext[PH_W-1:0];
    assign full_re = base_reg + START_RE[ph_idx] + QUARTER_TURN;
    assign full_im = base_reg + START_IM[ph_idx];

    assign prod_rnd = (prod_reg + P_W'(16384)) >>> 15;
    assign sg_ext   = G_W'($signed({1'b0, cfg.scatter_gain}));
    assign los_ext  = G_W'($signed({1'b0, cfg.los_gain}));

    always_comb
    begin
        case (step_reg)
            MIX_SR:
            begin
                mul_a = sr_reg;
                mul_b = sg_ext;
            end
            MIX_SI:
            begin
                mul_a = si_reg;
                mul_b = sg_ext;
            end
            MIX_XR_GR:
            begin
                mul_a = ACC_W'(xr_reg);
                mul_b = gr_reg;
            end
            MIX_XI_GI:
            begin
                mul_a = ACC_W'(xi_reg);
                mul_b = gi_reg;
            end
            MIX_XR_GI:
            begin
                mul_a = ACC_W'(xr_reg);
                mul_b = gi_reg;
            end
            MIX_XI_GR:
            begin
                mul_a = ACC_W'(xi_reg);
                mul_b = gr_reg;
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_acc)
                begin
                    state_next = cfg.enable ? ST_TONES : ST_FINISH;
                end
            end
            ST_TONES:
            begin
                if (last_tone)
                begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN:
            begin
                state_next = ST_MIX;
            end
            ST_MIX:
            begin
                if (step_reg == MIX_LAST)
                begin
                    state_next = ST_FINISH;
                end
            end
            ST_FINISH:
            begin
                if (!out_valid_reg || dout.ready)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // outputs of the sequencer
    always_comb
    begin
        in_ready = 1'b0;
        out_load = 1'b0;
        unique case (state_reg)
            ST_IDLE:   in_ready = 1'b1;
            ST_FINISH: out_load = !out_valid_reg || dout.ready;
            default:   ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            step_reg      <= MIX_SR;
            k_reg         <= '0;
            tone_vld_reg  <= 1'b0;
            theta_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            tone_vld_reg <= (state_reg == ST_TONES);
            if (state_reg == ST_TONES)
            begin
                k_reg <= k_reg + 1'b1;
            end
            else
            begin
                k_reg <= '0;
            end
            if (state_reg == ST_MIX)
            begin
                step_reg <= (step_reg == MIX_LAST) ? MIX_SR : mix_step_t'(step_reg + 1'b1);
            end
            else
            begin
                step_reg <= MIX_SR;
            end
            if (state_reg == ST_DRAIN)
            begin
                theta_reg <= theta_reg + cfg.phase_step;
            end
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (dout.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_acc)
        begin
            xr_reg     <= din.sample_re;
            xi_reg     <= din.sample_im;
            last_reg   <= din.last_in;
            bypass_reg <= !cfg.enable;
            base_reg   <= theta_reg;
            sr_reg     <= '0;
            si_reg     <= '0;
        end
        else
        begin
            if (state_reg == ST_TONES)
            begin
                ang_re_reg <= full_re[31 -: TRIG_BITS];
                ang_im_reg <= full_im[31 -: TRIG_BITS];
                base_reg   <= base_reg + theta_reg;
            end
            if (tone_vld_reg)
            begin
                sr_reg <= sr_reg + ACC_W'(sin_lookup(ang_re_reg));
                si_reg <= si_reg + ACC_W'(sin_lookup(ang_im_reg));
            end
        end

        if (state_reg == ST_MIX)
        begin
            prod_reg <= P_W'(mul_a) * P_W'(mul_b);
            case (step_reg)
                MIX_SI:    gr_reg <= G_W'(prod_rnd) + los_ext;
                MIX_XR_GR: gi_reg <= G_W'(prod_rnd);
                MIX_XI_GI: yr_reg <= Y_W'(prod_reg);
                MIX_XR_GI: yr_reg <= yr_reg - Y_W'(prod_reg);
                MIX_XI_GR: yi_reg <= Y_W'(prod_reg);
                MIX_LAST:  yi_reg <= yi_reg + Y_W'(prod_reg);
                default:   ;
            endcase
        end

        if (out_load)
        begin
            out_last_reg <= last_reg;
            if (bypass_reg)
            begin
                out_re_reg <= xr_reg;
                out_im_reg <= xi_reg;
            end
            else
            begin
                out_re_reg <= round_sat(yr_reg);
                out_im_reg <= round_sat(yi_reg);
            end
        end
    end

endmodule

/* src/sosf_regs.sv */
// sosf_regs: apb configuration registers of the fading channel
// depends on sosf_pkg
module sosf_regs (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [sosf_pkg::ADDR_W-1:0] paddr,
    input  logic [31:0]                pwdata,
    output logic [31:0]                prdata,
    output logic                       pready,
    output sosf_pkg::cfg_t             cfg
);
    import sosf_pkg::*;

    cfg_t     cfg_reg;
    reg_idx_t idx;
    logic     wr_en;

    assign idx    = reg_idx_t'(paddr[3:2]);
    assign wr_en  = psel && penable && pwrite;
    assign pready = 1'b1;
    assign cfg    = cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.enable       <= 1'b1;
            cfg_reg.phase_step   <= '0;
            cfg_reg.scatter_gain <= 16'd8192;
            cfg_reg.los_gain     <= '0;
        end
        else if (wr_en)
        begin
            unique case (idx)
                REG_ENABLE:       cfg_reg.enable       <= pwdata[0];
                REG_PHASE_STEP:   cfg_reg.phase_step   <= pwdata;
                REG_SCATTER_GAIN: cfg_reg.scatter_gain <= pwdata[15:0];
                REG_LOS_GAIN:     cfg_reg.los_gain     <= pwdata[15:0];
                default:          ;
            endcase
        end
    end

    always_comb
    begin
        unique case (idx)
            REG_ENABLE:       prdata = {31'd0, cfg_reg.enable};
            REG_PHASE_STEP:   prdata = cfg_reg.phase_step;
            REG_SCATTER_GAIN: prdata = {16'd0, cfg_reg.scatter_gain};
            REG_LOS_GAIN:     prdata = {16'd0, cfg_reg.los_gain};
            default:          prdata = '0;
        endcase
    end

endmodule
